// ===== rtl/core/clipped_color_key_blitter_macros.svh =====
// assertion macros for the clipped color key blitter checker
// expects signals named clock and reset in the scope of each use
`ifndef CLIPPED_COLOR_KEY_BLITTER_MACROS_SVH
`define CLIPPED_COLOR_KEY_BLITTER_MACROS_SVH

// condition and consequence in the same cycle
`define CCB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence in the cycle after the condition
`define CCB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ccb_pkg.sv =====
// shared types and constants of the clipped color key blitter
// no dependencies; imported by the frame memory, the top level and the checker
`default_nettype none

package ccb_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int PIXEL_BITS  = 32;

   localparam int X_BITS      = $clog2(MAX_WIDTH);
   localparam int Y_BITS      = $clog2(MAX_HEIGHT);
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

   // canvas size registers and the key register
   localparam int DIM_BITS    = 9;
   localparam int KEY_BITS    = 32;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   // signed coordinates: 16 bit position plus unsigned 16 bit offsets
   localparam int COORD_BITS  = 18;

   // row base is y times the raw width register; sum adds x
   localparam int ROW_BITS    = Y_BITS + DIM_BITS;
   localparam int SUM_BITS    = ((ROW_BITS > ADDR_BITS) ? ROW_BITS : ADDR_BITS) + 1;

   localparam int REQ_DATA_BITS = 160;
   localparam int REQ_USER_BITS = 3;
   localparam int READ_BITS     = 32;
   localparam int RSP_DATA_BITS = 40;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(256);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(256);
   localparam logic [KEY_BITS-1:0] KEY_RESET    = 32'h00FF_00FF;

   typedef logic [ADDR_BITS-1:0]         addr_type;
   typedef logic [PIXEL_BITS-1:0]        pix_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef enum logic [2:0] {
      OP_CLEAR = 3'd0,
      OP_PIXEL = 3'd1,
      OP_RECT  = 3'd2,
      OP_IMAGE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_CANVAS_WIDTH    = 2'd0,
      CSR_CANVAS_HEIGHT   = 2'd1,
      CSR_TRANSPARENT_KEY = 2'd2
   } csr_index_type;

   // frame memory access for one cycle
   typedef struct packed {
      logic     wr_en;
      logic     rd_en;
      addr_type addr;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/ccb_frame_ram.sv =====
// frame store: single port synchronous ram with a registered read
// depends on ccb_pkg for depth, pixel width and the access struct
`default_nettype none

module ccb_frame_ram
   import ccb_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_ctl_type mem_ctl,
   input  wire pix_type     wr_data,
   output pix_type          rd_data
);

   pix_type frame_mem [STORE_DEPTH];
   pix_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         frame_mem[mem_ctl.addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= frame_mem[mem_ctl.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/clipped_color_key_blitter.sv =====
// clipped color key blitter top level: item sequencer, clip logic, csr bank
// depends on ccb_pkg and ccb_frame_ram
//
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tuser: op; tdata: positions, spans, window, pixel
// rsp       out  rsp_tvalid/rsp_tready  tdata: read_data, wrote_any
// csr       in   csr_we                 csr_addr selects register, csr_wdata value
//
// one item at a time: accept, box setup, clip, row multiply, then a scan of one
// canvas pixel per cycle, a read step for a read, then the result register load;
// items that touch nothing skip the row multiply, the scan and the read step;
// the single frame memory port sets the fill rate
// synchronous reset clears control and csr registers; the frame store is not
// cleared, its contents are undefined until written
// a result waiting in rsp holds the sequencer in its last step until taken
`default_nettype none

module clipped_color_key_blitter
   import ccb_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // pos_x, pos_y, span_w, span_h, win_x, win_y, src_x, src_y (16 each), pixel (32)
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // op (3)
   input  wire logic [REQ_USER_BITS-1:0] req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // read_data (32), wrote_any (1), zero pad (7)
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_CLIP,
      S_MUL,
      S_RUN,
      S_READ,
      S_DONE
   } state_type;

   state_type state_ff;

   // csr bank
   logic [DIM_BITS-1:0] canvas_width_ff;
   logic [DIM_BITS-1:0] canvas_height_ff;
   logic [KEY_BITS-1:0] key_ff;

   // latched item
   logic [REQ_USER_BITS-1:0] op_ff;
   logic signed [15:0]       pos_x_ff;
   logic signed [15:0]       pos_y_ff;
   logic [15:0]              span_w_ff;
   logic [15:0]              span_h_ff;
   logic [15:0]              win_x_ff;
   logic [15:0]              win_y_ff;
   logic [15:0]              src_x_ff;
   logic [15:0]              src_y_ff;
   pix_type                  pixel_ff;

   // box before clipping, half open
   coord_type bx0_ff, by0_ff, bx1_ff, by1_ff;
   logic      en_ff;
   coord_type bx0_in, by0_in, bx1_in, by1_in;
   logic      en_in;

   // clipped box
   coord_type x0c_in, y0c_in, x1c_in, y1c_in;
   coord_type x1m_in, y1m_in;
   logic      hit_in;
   logic      hit_ff;

   // scan counters
   logic [X_BITS-1:0]   x_first_ff, x_last_ff, x_cur_ff;
   logic [Y_BITS-1:0]   y_last_ff, y_cur_ff;
   logic [ROW_BITS-1:0] row_base_ff;
   logic [SUM_BITS-1:0] addr_sum;

   logic [READ_BITS-1:0]     read_ff;
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   logic        is_read;
   logic        rsp_free;
   coord_type   eff_w, eff_h;
   coord_type   dx, dy;
   logic [16:0] win_x_end, win_y_end;
   logic        win_ok;

   mem_ctl_type mem_ctl;
   pix_type     rd_data;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign is_read    = (op_ff == OP_READ);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // width register larger than the store acts as the store width
   assign eff_w = (COORD_BITS'(canvas_width_ff) > COORD_BITS'(MAX_WIDTH)) ?
                  coord_type'(MAX_WIDTH) : coord_type'(canvas_width_ff);
   assign eff_h = (COORD_BITS'(canvas_height_ff) > COORD_BITS'(MAX_HEIGHT)) ?
                  coord_type'(MAX_HEIGHT) : coord_type'(canvas_height_ff);

   // source window test, no wraparound
   assign win_x_end = {1'b0, win_x_ff} + {1'b0, span_w_ff};
   assign win_y_end = {1'b0, win_y_ff} + {1'b0, span_h_ff};
   assign win_ok    = ({1'b0, src_x_ff} >= {1'b0, win_x_ff}) &&
                      ({1'b0, src_x_ff} < win_x_end) &&
                      ({1'b0, src_y_ff} >= {1'b0, win_y_ff}) &&
                      ({1'b0, src_y_ff} < win_y_end);

   // image pixel lands at origin plus its offset inside the window
   assign dx = coord_type'(pos_x_ff) + (coord_type'(src_x_ff) - coord_type'(win_x_ff));
   assign dy = coord_type'(pos_y_ff) + (coord_type'(src_y_ff) - coord_type'(win_y_ff));

   // every op becomes a box; single pixel ops are one by one boxes
   always_comb begin
      bx0_in = coord_type'(pos_x_ff);
      by0_in = coord_type'(pos_y_ff);
      bx1_in = coord_type'(pos_x_ff) + coord_type'(1);
      by1_in = coord_type'(pos_y_ff) + coord_type'(1);
      en_in  = 1'b0;
      unique case (op_type'(op_ff))
         OP_CLEAR: begin
            bx0_in = '0;
            by0_in = '0;
            bx1_in = eff_w;
            by1_in = eff_h;
            en_in  = 1'b1;
         end
         OP_PIXEL, OP_READ: begin
            en_in = 1'b1;
         end
         OP_RECT: begin
            bx1_in = coord_type'(pos_x_ff) + coord_type'(span_w_ff);
            by1_in = coord_type'(pos_y_ff) + coord_type'(span_h_ff);
            en_in  = 1'b1;
         end
         OP_IMAGE: begin
            bx0_in = dx;
            by0_in = dy;
            bx1_in = dx + coord_type'(1);
            by1_in = dy + coord_type'(1);
            // transparent key taken at pixel width
            en_in  = win_ok && (pixel_ff != key_ff[PIXEL_BITS-1:0]);
         end
         default: begin
            en_in = 1'b0;
         end
      endcase
   end

   // clip to the canvas
   always_comb begin
      x0c_in = (bx0_ff < coord_type'(0)) ? coord_type'(0) : bx0_ff;
      y0c_in = (by0_ff < coord_type'(0)) ? coord_type'(0) : by0_ff;
      x1c_in = (bx1_ff > eff_w) ? eff_w : bx1_ff;
      y1c_in = (by1_ff > eff_h) ? eff_h : by1_ff;
      x1m_in = x1c_in - coord_type'(1);
      y1m_in = y1c_in - coord_type'(1);
      hit_in = en_ff && (x0c_in < x1c_in) && (y0c_in < y1c_in);
   end

   // address uses the raw width register as stride; beyond the store maps to zero
   assign addr_sum = SUM_BITS'(row_base_ff) + SUM_BITS'(x_cur_ff);

   // writes finish at the edge they are issued and items never overlap, so a
   // read always sees every earlier write without forwarding
   always_comb begin
      mem_ctl.wr_en = (state_ff == S_RUN) && !is_read;
      mem_ctl.rd_en = (state_ff == S_RUN) && is_read;
      mem_ctl.addr  = (addr_sum < SUM_BITS'(STORE_DEPTH)) ?
                      addr_sum[ADDR_BITS-1:0] : '0;
   end

   ccb_frame_ram u_frame_ram (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_data (pixel_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         canvas_width_ff  <= WIDTH_RESET;
         canvas_height_ff <= HEIGHT_RESET;
         key_ff           <= KEY_RESET;
      end else begin
         // csr writes must only arrive while idle; the block itself does not enforce it
         if (csr_we) begin
            unique case (csr_addr)
               CSR_CANVAS_WIDTH:    canvas_width_ff  <= csr_wdata[DIM_BITS-1:0];
               CSR_CANVAS_HEIGHT:   canvas_height_ff <= csr_wdata[DIM_BITS-1:0];
               CSR_TRANSPARENT_KEY: key_ff           <= csr_wdata[KEY_BITS-1:0];
               default: ;
            endcase
         end

         // a taken result frees the register unless the done step reloads it
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff     <= req_tuser;
                  pos_x_ff  <= req_tdata[15:0];
                  pos_y_ff  <= req_tdata[31:16];
                  span_w_ff <= req_tdata[47:32];
                  span_h_ff <= req_tdata[63:48];
                  win_x_ff  <= req_tdata[79:64];
                  win_y_ff  <= req_tdata[95:80];
                  src_x_ff  <= req_tdata[111:96];
                  src_y_ff  <= req_tdata[127:112];
                  pixel_ff  <= req_tdata[128 +: PIXEL_BITS];
                  read_ff   <= '0;
                  state_ff  <= S_CALC;
               end
            end
            S_CALC: begin
               bx0_ff   <= bx0_in;
               by0_ff   <= by0_in;
               bx1_ff   <= bx1_in;
               by1_ff   <= by1_in;
               en_ff    <= en_in;
               state_ff <= S_CLIP;
            end
            S_CLIP: begin
               hit_ff     <= hit_in;
               x_first_ff <= x0c_in[X_BITS-1:0];
               x_cur_ff   <= x0c_in[X_BITS-1:0];
               x_last_ff  <= x1m_in[X_BITS-1:0];
               y_cur_ff   <= y0c_in[Y_BITS-1:0];
               y_last_ff  <= y1m_in[Y_BITS-1:0];
               state_ff   <= hit_in ? S_MUL : S_DONE;
            end
            S_MUL: begin
               row_base_ff <= ROW_BITS'(y_cur_ff) * ROW_BITS'(canvas_width_ff);
               state_ff    <= S_RUN;
            end
            S_RUN: begin
               // one canvas pixel per cycle, row by row
               if (x_cur_ff == x_last_ff) begin
                  x_cur_ff <= x_first_ff;
                  if (y_cur_ff == y_last_ff) begin
                     state_ff <= is_read ? S_READ : S_DONE;
                  end else begin
                     y_cur_ff    <= Y_BITS'(y_cur_ff + 1'b1);
                     row_base_ff <= row_base_ff + ROW_BITS'(canvas_width_ff);
                  end
               end else begin
                  x_cur_ff <= X_BITS'(x_cur_ff + 1'b1);
               end
            end
            S_READ: begin
               read_ff  <= READ_BITS'(rd_data);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {7'b0, hit_ff && !is_read, read_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ccb_checker.sv =====
// port level checker for the clipped color key blitter, bound to the top level
// depends on ccb_pkg and clipped_color_key_blitter_macros.svh
`default_nettype none
`include "clipped_color_key_blitter_macros.svh"

module ccb_checker
   import ccb_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // a stalled result stays offered
   `CCB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp item dropped while stalled")

   // a stalled result keeps its payload
   `CCB_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp item changed while stalled")

   // items are worked one at a time
   `CCB_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "req taken while an item is in work")

   // an item that reports a write returns no read data
   `CCB_ASSERT_SAME(a_write_no_data, rsp_tvalid && rsp_tdata[READ_BITS], rsp_tdata[READ_BITS-1:0] == '0, "writing item returned read data")

endmodule

bind clipped_color_key_blitter ccb_checker u_ccb_checker (.*);

`default_nettype wire
